>>> design/led_pkg.sv
// ----------------------------------------------------------------------------
// led_pkg
// Constants and round function for the LED-128 block cipher datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package led_pkg;

  localparam int unsigned LED_BLOCK_W     = 64;
  localparam int unsigned LED_RCON_DEPTH  = 48;
  localparam int unsigned LED_ROUND_COUNT = 48;

  // register indexes of the configuration port
  localparam logic LED_REG_KEY_FIRST  = 1'b0;
  localparam logic LED_REG_KEY_SECOND = 1'b1;

  // key-size byte mixed into the round constants (128-bit key)
  localparam logic [7:0] LED_KEY_SIZE = 8'h80;
  localparam logic [3:0] LED_KS_HI    = LED_KEY_SIZE[7:4];
  localparam logic [3:0] LED_KS_LO    = LED_KEY_SIZE[3:0];

  localparam logic [3:0] LED_SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  localparam logic [3:0] LED_MDS [4][4] = '{
    '{4'h4, 4'h1, 4'h2, 4'h2},
    '{4'h8, 4'h6, 4'h5, 4'h6},
    '{4'hB, 4'hE, 4'hA, 4'h9},
    '{4'h2, 4'h2, 4'hF, 4'hB}
  };

  localparam logic [5:0] LED_RCON [LED_RCON_DEPTH] = '{
    6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B, 6'h37, 6'h2F,
    6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E, 6'h1D, 6'h3A, 6'h35, 6'h2B,
    6'h16, 6'h2C, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E,
    6'h1C, 6'h38, 6'h31, 6'h23, 6'h06, 6'h0D, 6'h1B, 6'h36, 6'h2D, 6'h1A,
    6'h34, 6'h29, 6'h12, 6'h24, 6'h08, 6'h11, 6'h22, 6'h04
  };

  // multiply in GF(2^4) modulo x^4+x+1
  function automatic logic [3:0] led_gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [3:0] x;
    acc = 4'h0;
    x   = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

  // add constants, sub cells, shift rows, mix columns serial
  function automatic logic [63:0] led_cipher_round(input logic [63:0] s,
                                                   input logic [5:0]  rc);
    logic [3:0]  c [16];
    logic [3:0]  t [16];
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [3:0]  m;
    logic [63:0] o;
    hi = {1'b0, rc[5:3]};
    lo = {1'b0, rc[2:0]};
    o  = '0;
    for (int i = 0; i < 16; i++) begin
      c[i] = s[63-4*i -: 4];
    end
    c[0]  = c[0]  ^ (4'h0 ^ LED_KS_HI);
    c[4]  = c[4]  ^ (4'h1 ^ LED_KS_HI);
    c[8]  = c[8]  ^ (4'h2 ^ LED_KS_LO);
    c[12] = c[12] ^ (4'h3 ^ LED_KS_LO);
    c[1]  = c[1]  ^ hi;
    c[9]  = c[9]  ^ hi;
    c[5]  = c[5]  ^ lo;
    c[13] = c[13] ^ lo;
    for (int i = 0; i < 16; i++) begin
      c[i] = LED_SBOX[c[i]];
    end
    // row i rotates left by i cells
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        t[4*i+j] = c[4*i+((i+j)%4)];
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        m = 4'h0;
        for (int k = 0; k < 4; k++) begin
          m = m ^ led_gf_mul(LED_MDS[i][k], t[4*k+j]);
        end
        o[63-4*(4*i+j) -: 4] = m;
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

>>> design/led_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// led_block_encrypt_core
// LED-128 encryption, fully unrolled: one round per pipeline stage.
//
//   channel   signals                          direction  transfer when
//   input     start_i, plaintext_i, busy_o     in         start_i & !busy_o
//   result    done_o, ciphertext_o             out        done_o (one cycle)
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i in         cfg_we_i
//
// the path is one register stage per round followed by the output register,
// which holds the final key add.
// a new block may enter every cycle; busy_o stays low.
// reset clears the valid bits of all stages and both key halves.
// results are never held off, so the pipeline always advances.
// ----------------------------------------------------------------------------
`default_nettype none

module led_block_encrypt_core #(
  parameter int unsigned ROUND_COUNT = led_pkg::LED_ROUND_COUNT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [led_pkg::LED_BLOCK_W-1:0] plaintext_i,
  output logic                                 done_o,
  output logic [led_pkg::LED_BLOCK_W-1:0]      ciphertext_o,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [led_pkg::LED_BLOCK_W-1:0] cfg_wdata_i
);
  import led_pkg::*;

  localparam int unsigned NUM_STEPS  = ROUND_COUNT / 4;
  localparam int unsigned NUM_ROUNDS = NUM_STEPS * 4;

  logic [LED_BLOCK_W-1:0] key_first_q;
  logic [LED_BLOCK_W-1:0] key_second_q;
  logic [LED_BLOCK_W-1:0] final_key;

  logic [NUM_ROUNDS:0]    vld;
  logic [LED_BLOCK_W-1:0] st [NUM_ROUNDS+1];

  logic                   done_q;
  logic [LED_BLOCK_W-1:0] ciphertext_d;
  logic [LED_BLOCK_W-1:0] ciphertext_q;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q  <= '0;
      key_second_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        LED_REG_KEY_FIRST:  key_first_q  <= cfg_wdata_i;
        LED_REG_KEY_SECOND: key_second_q <= cfg_wdata_i;
      endcase
    end
  end

  assign vld[0] = start_i;
  assign st[0]  = plaintext_i;

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    logic [LED_BLOCK_W-1:0] rkey;
    // key half alternates per step, added only on the first round of a step
    if ((r % 4) != 0) begin : g_nokey
      assign rkey = '0;
    end else if (((r / 4) % 2) == 1) begin : g_second
      assign rkey = key_second_q;
    end else begin : g_first
      assign rkey = key_first_q;
    end

    led_round_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[r]),
      .state_i (st[r]),
      .key_i   (rkey),
      .rcon_i  (LED_RCON[r]),
      .valid_o (vld[r+1]),
      .state_o (st[r+1])
    );
  end

  assign final_key    = ((NUM_STEPS % 2) == 1) ? key_second_q : key_first_q;
  assign ciphertext_d = st[NUM_ROUNDS] ^ final_key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[NUM_ROUNDS];
    end
  end

  always_ff @(posedge clk_i) begin
    ciphertext_q <= ciphertext_d;
  end

  assign busy_o       = 1'b0;
  assign done_o       = done_q;
  assign ciphertext_o = ciphertext_q;

  // an accepted block enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> vld[1])
    else $error("accepted block did not enter the pipeline");

  // no strobe while every round stage is empty
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld[NUM_ROUNDS:1] == '0) |=> !done_o)
    else $error("result strobe with empty pipeline");

  // a block in the last round stage is delivered next cycle
  a_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[NUM_ROUNDS] |=> done_o)
    else $error("finished block was not delivered");

endmodule

`default_nettype wire

>>> design/led_round_stage.sv
// ----------------------------------------------------------------------------
// led_round_stage
// One pipeline stage: optional key addition followed by one cipher round.
// ----------------------------------------------------------------------------
`default_nettype none

module led_round_stage (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [led_pkg::LED_BLOCK_W-1:0] state_i,
  input  wire logic [led_pkg::LED_BLOCK_W-1:0] key_i,
  input  wire logic [5:0]                      rcon_i,
  output logic                                 valid_o,
  output logic [led_pkg::LED_BLOCK_W-1:0]      state_o
);
  import led_pkg::*;

  logic                   valid_q;
  logic [LED_BLOCK_W-1:0] state_d;
  logic [LED_BLOCK_W-1:0] state_q;

  // key is zero on rounds that do not open a step
  assign state_d = led_cipher_round(state_i ^ key_i, rcon_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

`default_nettype wire
